>>> hdl/lfps_pkg.sv
// Package for the line-follower PID steering block.
// Holds the item structs, register indexes and widths shared by all modules.
// No dependencies.
package lfps_pkg;

  localparam int unsigned SensorW = 16;
  localparam int unsigned GainW   = 32;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned LostW   = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned SumW    = 45;
  localparam int unsigned TermLog = 42;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_MAX_SPEED   = 3'd4,
    REG_REV_OFFSET  = 3'd5,
    REG_LOST_ERROR  = 3'd6,
    REG_LOST_ENABLE = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                opcode;
    logic [SensorW-1:0]  sensor_bits;
  } in_t;

  typedef struct packed {
    logic [SpeedW-1:0]   left_duty;
    logic                left_reverse;
    logic [SpeedW-1:0]   right_duty;
    logic                right_reverse;
    logic signed [7:0]   error_half;
    logic signed [15:0]  pid_output;
  } out_t;

  typedef struct packed {
    logic               hit;
    logic signed [7:0]  err;
  } run_t;

  typedef struct packed {
    logic [SpeedW-1:0]  duty;
    logic               reverse;
  } wheel_t;

endpackage

>>> hdl/lfps_decode.sv
// Sensor run decoder for the line-follower PID steering block.
// Finds a single run of set sensor bits and turns it into a half-step error.
// Depends on lfps_pkg.
module lfps_decode (
  input  logic [lfps_pkg::SensorW-1:0] bits_i,
  output lfps_pkg::run_t               run_o
);
  import lfps_pkg::*;

  logic [3:0]         lo;
  logic [4:0]         cnt;
  logic [SensorW-1:0] low_bit;
  logic [SensorW:0]   carry_sum;
  logic               contig;
  logic               len_ok;

  always_comb begin
    lo  = 4'd0;
    cnt = 5'd0;
    for (int i = SensorW - 1; i >= 0; i--) begin
      if (bits_i[i]) begin
        lo = 4'(i);
      end
    end
    for (int i = 0; i < SensorW; i++) begin
      cnt = cnt + 5'(bits_i[i]);
    end
  end

  assign low_bit   = bits_i & (~bits_i + 1'b1);
  assign carry_sum = {1'b0, bits_i} + {1'b0, low_bit};
  assign contig    = (bits_i != '0) && ((carry_sum[SensorW-1:0] & bits_i) == '0);
  assign len_ok    = ((cnt >= 5'd2) && (cnt <= 5'd5)) ||
                     ((cnt == 5'd1) && ((lo == 4'd0) || (lo == 4'd15)));

  assign run_o.hit = contig && len_ok;
  assign run_o.err = $signed({3'b000, lo, 1'b0} + {3'b000, cnt} - 8'd16);

endmodule

>>> hdl/lfps_wheel.sv
// Wheel duty mapper for the line-follower PID steering block.
// Saturates a wheel value and maps it to duty and direction with a dead band.
// Depends on lfps_pkg.
module lfps_wheel (
  input  logic signed [17:0]          value_i,
  input  logic [lfps_pkg::SpeedW-1:0] max_speed_i,
  input  logic [lfps_pkg::SpeedW-1:0] rev_offset_i,
  output lfps_pkg::wheel_t            wheel_o
);
  import lfps_pkg::*;

  logic signed [15:0] sat;
  logic [16:0]        neg_mag;
  logic [16:0]        rev_duty;

  always_comb begin
    priority if (value_i > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (value_i < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = value_i[15:0];
    end
  end

  assign neg_mag  = 17'd0 - {sat[15], sat};
  assign rev_duty = {2'b00, rev_offset_i} + {1'b0, neg_mag[16:1]};

  always_comb begin
    priority if (!sat[15]) begin
      wheel_o.reverse = 1'b0;
      wheel_o.duty    = (sat[14:0] > max_speed_i) ? max_speed_i : sat[14:0];
    end else if (neg_mag > {2'b00, rev_offset_i}) begin
      wheel_o.reverse = 1'b1;
      wheel_o.duty    = (rev_duty > {2'b00, max_speed_i}) ? max_speed_i : rev_duty[14:0];
    end else begin
      wheel_o.reverse = 1'b0;
      wheel_o.duty    = '0;
    end
  end

endmodule

>>> hdl/line_follower_pid_steering_top.sv
// Top level of the line-follower PID steering block.
// Decodes sensor scans, runs the PID controller and maps wheel duties.
// Depends on lfps_pkg, lfps_decode and lfps_wheel.
//
// Usage: each input item carries an opcode and a 16-bit sensor scan on a
// valid/ready channel; each accepted item yields exactly one result item on
// the output valid/ready channel, in order. A clear item zeroes the
// controller state and returns an all-zero result.
// Each item passes through five registered stages, and a new item is
// taken every cycle while the pipeline is not stalled. The stages are
// error decode with state update, the three gain multipliers, the term sum,
// the output truncation, and the wheel mapping into the output register.
// When the receiver stalls, the stages fill up behind the output register
// and input ready drops only once every stage holds an item.
// Configuration is a plain write port: cfg_we_i writes cfg_data_i into the
// register at cfg_idx_i, to be used only while the block is idle.
// Reset clears the pipeline and the controller state and loads the default configuration.
module line_follower_pid_steering_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfps_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfps_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lfps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::CfgDatW-1:0]  cfg_data_i
);
  import lfps_pkg::*;

  localparam logic signed [7:0] LostThr = 8'sd6;
  localparam logic [63:0] TermMax = 64'd1 << TermLog;

  // Configuration registers.
  logic [GainW-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [SpeedW-1:0] base_speed_q, max_speed_q, rev_offset_q;
  logic [LostW-1:0]  lost_err_q;
  logic              lost_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= 32'd13107200;
      integ_gain_q <= 32'd1114;
      deriv_gain_q <= 32'd36044800;
      base_speed_q <= 15'd950;
      max_speed_q  <= 15'd1000;
      rev_offset_q <= 15'd400;
      lost_err_q   <= 6'd10;
      lost_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:   prop_gain_q  <= cfg_data_i;
        REG_INTEG_GAIN:  integ_gain_q <= cfg_data_i;
        REG_DERIV_GAIN:  deriv_gain_q <= cfg_data_i;
        REG_BASE_SPEED:  base_speed_q <= cfg_data_i[SpeedW-1:0];
        REG_MAX_SPEED:   max_speed_q  <= cfg_data_i[SpeedW-1:0];
        REG_REV_OFFSET:  rev_offset_q <= cfg_data_i[SpeedW-1:0];
        REG_LOST_ERROR:  lost_err_q   <= cfg_data_i[LostW-1:0];
        REG_LOST_ENABLE: lost_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage handshake.
  logic [5:1] vld_q;
  logic [5:1] en;

  assign en[5]      = !vld_q[5] || out_ready_i;
  assign en[4]      = !vld_q[4] || en[5];
  assign en[3]      = !vld_q[3] || en[4];
  assign en[2]      = !vld_q[2] || en[3];
  assign en[1]      = !vld_q[1] || en[2];
  assign in_ready_o = en[1];
  assign out_valid_o = vld_q[5];

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_valid_i;
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
      if (en[5]) vld_q[5] <= vld_q[4];
    end
  end

  // Stage 1: error decode and controller state update.
  run_t               run;
  logic signed [7:0]  lost_val;
  logic signed [7:0]  err_d;
  logic signed [32:0] isum_wide;
  logic signed [31:0] isum_d;
  logic signed [7:0]  last_err_q;
  logic signed [31:0] integ_q;
  logic               clr_in;

  lfps_decode u_decode (
    .bits_i (in_data_i.sensor_bits),
    .run_o  (run)
  );

  assign clr_in   = (opcode_e'(in_data_i.opcode) == OP_CLEAR);
  assign lost_val = $signed({1'b0, lost_err_q, 1'b0});

  always_comb begin
    err_d = last_err_q;
    if (in_data_i.sensor_bits == '0) begin
      if (lost_en_q && (last_err_q < -LostThr)) begin
        err_d = -lost_val;
      end else if (lost_en_q && (last_err_q > LostThr)) begin
        err_d = lost_val;
      end
    end else if (run.hit) begin
      err_d = run.err;
    end
  end

  assign isum_wide = {integ_q[31], integ_q} + 33'(err_d);

  always_comb begin
    priority if (isum_wide > 33'sh0_7fff_ffff) begin
      isum_d = 32'sh7fff_ffff;
    end else if (isum_wide < -33'sh0_8000_0000) begin
      isum_d = 32'sh8000_0000;
    end else begin
      isum_d = isum_wide[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
    end else if (accept) begin
      if (clr_in) begin
        last_err_q <= '0;
        integ_q    <= '0;
      end else begin
        last_err_q <= err_d;
        integ_q    <= isum_d;
      end
    end
  end

  logic               s1_clr_q;
  logic signed [7:0]  s1_err_q;
  logic signed [8:0]  s1_derr_q;
  logic signed [31:0] s1_isum_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_clr_q  <= clr_in;
      s1_err_q  <= err_d;
      s1_derr_q <= {err_d[7], err_d} - {last_err_q[7], last_err_q};
      s1_isum_q <= isum_d;
    end
  end

  // Stage 2: gain products on magnitudes.
  logic [6:0]  mag_e;
  logic [7:0]  mag_d;
  logic [31:0] mag_i;

  assign mag_e = s1_err_q[7]  ? 7'(-s1_err_q)   : s1_err_q[6:0];
  assign mag_d = s1_derr_q[8] ? 8'(-s1_derr_q)  : s1_derr_q[7:0];
  assign mag_i = s1_isum_q[31] ? 32'(-s1_isum_q) : s1_isum_q;

  logic              s2_clr_q;
  logic signed [7:0] s2_err_q;
  logic [38:0]       s2_pe_q;
  logic [39:0]       s2_pd_q;
  logic [63:0]       s2_pi_q;
  logic              s2_ne_q, s2_nd_q, s2_ni_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_clr_q <= s1_clr_q;
      s2_err_q <= s1_err_q;
      s2_pe_q  <= prop_gain_q * mag_e;
      s2_pd_q  <= deriv_gain_q * mag_d;
      s2_pi_q  <= integ_gain_q * mag_i;
      s2_ne_q  <= s1_err_q[7];
      s2_nd_q  <= s1_derr_q[8];
      s2_ni_q  <= s1_isum_q[31];
    end
  end

  // Stage 3: clamp the integral term and add the three terms.
  logic [TermLog:0]       pi_clamp;
  logic signed [SumW-1:0] term_e, term_d, term_i;

  assign pi_clamp = (s2_pi_q > TermMax) ? TermMax[TermLog:0] : s2_pi_q[TermLog:0];
  assign term_e = s2_ne_q ? -$signed(SumW'(s2_pe_q))  : $signed(SumW'(s2_pe_q));
  assign term_d = s2_nd_q ? -$signed(SumW'(s2_pd_q))  : $signed(SumW'(s2_pd_q));
  assign term_i = s2_ni_q ? -$signed(SumW'(pi_clamp)) : $signed(SumW'(pi_clamp));

  logic                   s3_clr_q;
  logic signed [7:0]      s3_err_q;
  logic signed [SumW-1:0] s3_sum_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_clr_q <= s2_clr_q;
      s3_err_q <= s2_err_q;
      s3_sum_q <= term_e + term_d + term_i;
    end
  end

  // Stage 4: scale to integer, truncating toward zero, and saturate.
  logic [SumW-1:0]    sum_mag;
  logic [SumW-18:0]   sum_int;
  logic signed [15:0] out16_d;

  assign sum_mag = s3_sum_q[SumW-1] ? SumW'(-s3_sum_q) : SumW'(s3_sum_q);
  assign sum_int = sum_mag[SumW-1:17];

  always_comb begin
    if (s3_sum_q[SumW-1]) begin
      out16_d = (sum_int >= (SumW-17)'(32768)) ? 16'sh8000 : -$signed(16'(sum_int));
    end else begin
      out16_d = (sum_int >= (SumW-17)'(32767)) ? 16'sh7fff : $signed(16'(sum_int));
    end
  end

  logic               s4_clr_q;
  logic signed [7:0]  s4_err_q;
  logic signed [15:0] s4_out16_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_clr_q   <= s3_clr_q;
      s4_err_q   <= s3_err_q;
      s4_out16_q <= out16_d;
    end
  end

  // Stage 5: wheel mapping into the output register.
  logic signed [17:0] left_val, right_val;
  wheel_t             left_w, right_w;
  out_t               res_d, res_q;

  assign left_val  = $signed({3'b000, base_speed_q}) - 18'(s4_out16_q);
  assign right_val = $signed({3'b000, base_speed_q}) + 18'(s4_out16_q);

  lfps_wheel u_wheel_left (
    .value_i      (left_val),
    .max_speed_i  (max_speed_q),
    .rev_offset_i (rev_offset_q),
    .wheel_o      (left_w)
  );

  lfps_wheel u_wheel_right (
    .value_i      (right_val),
    .max_speed_i  (max_speed_q),
    .rev_offset_i (rev_offset_q),
    .wheel_o      (right_w)
  );

  always_comb begin
    if (s4_clr_q) begin
      res_d = '0;
    end else begin
      res_d.left_duty     = left_w.duty;
      res_d.left_reverse  = left_w.reverse;
      res_d.right_duty    = right_w.duty;
      res_d.right_reverse = right_w.reverse;
      res_d.error_half    = s4_err_q;
      res_d.pid_output    = s4_out16_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule

>>> bench/line_follower_pid_steering_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_follower_pid_steering_top: random and directed sensor
// scans under several gain settings, checked against an in-bench PID steering predictor.
// Depends on lfps_pkg and the line_follower_pid_steering_top RTL.
module line_follower_pid_steering_top_tb;
  import lfps_pkg::*;

  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SettleTicks = 8;
  localparam int unsigned PhaseItems  = 160;
  localparam int unsigned NumPhases   = 9;

  class steer_checker;
    logic [31:0] kp, ki, kd;
    int          base_spd, max_spd, rev_off, lost_err;
    bit          lost_en;
    int          last_err;
    int          integ_acc;
    out_t        pending_steer[$];
    int unsigned mismatches;

    function new();
      kp = 32'd13107200;
      ki = 32'd1114;
      kd = 32'd36044800;
      base_spd = 950;
      max_spd = 1000;
      rev_off = 400;
      lost_err = 10;
      lost_en = 1'b1;
      last_err = 0;
      integ_acc = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e r, logic [31:0] v);
      case (r)
        REG_PROP_GAIN:   kp = v;
        REG_INTEG_GAIN:  ki = v;
        REG_DERIV_GAIN:  kd = v;
        REG_BASE_SPEED:  base_spd = int'(v[SpeedW-1:0]);
        REG_MAX_SPEED:   max_spd = int'(v[SpeedW-1:0]);
        REG_REV_OFFSET:  rev_off = int'(v[SpeedW-1:0]);
        REG_LOST_ERROR:  lost_err = int'(v[LostW-1:0]);
        REG_LOST_ENABLE: lost_en = v[0];
        default: ;
      endcase
    endfunction

    function bit find_run(logic [15:0] bits, output int err);
      int unsigned lo, len, s;
      err = 0;
      if (bits == '0) return 1'b0;
      lo = 0;
      while (!bits[lo]) lo++;
      s = 32'(bits) >> lo;
      if ((s & (s + 32'd1)) != 0) return 1'b0;
      len = 0;
      while (((s >> len) & 32'd1) != 0) len++;
      if (len > 5) return 1'b0;
      if (len == 1 && lo != 0 && lo != 15) return 1'b0;
      err = int'(2 * lo + len - 1) - 15;
      return 1'b1;
    endfunction

    function longint scale_term(logic [31:0] gain, longint x);
      longint unsigned mag, prod;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      prod = 64'(gain) * mag;
      if (prod > (64'd1 << TermLog)) prod = 64'd1 << TermLog;
      return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function wheel_t drive_wheel(int v);
      wheel_t w;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      w.reverse = 1'b0;
      if (v >= 0) begin
        w.duty = SpeedW'((v > max_spd) ? max_spd : v);
      end else if (v < -rev_off) begin
        w.duty = SpeedW'((rev_off + (-v) / 2 > max_spd) ? max_spd : rev_off + (-v) / 2);
        w.reverse = 1'b1;
      end else begin
        w.duty = '0;
      end
      return w;
    endfunction

    function out_t steer_step(in_t it);
      out_t   r;
      int     e, run_err, pid;
      longint acc, total, q;
      longint unsigned mag;
      wheel_t lw, rw;
      r = '0;
      if (it.opcode == OP_CLEAR) begin
        last_err = 0;
        integ_acc = 0;
        return r;
      end
      e = last_err;
      if (it.sensor_bits == '0) begin
        if (lost_en) begin
          if (last_err < -6) e = -2 * lost_err;
          else if (last_err > 6) e = 2 * lost_err;
        end
      end else if (find_run(it.sensor_bits, run_err)) begin
        e = run_err;
      end
      acc = longint'(integ_acc) + e;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      integ_acc = int'(acc);
      total = scale_term(kp, e) + scale_term(ki, acc) + scale_term(kd, longint'(e) - last_err);
      last_err = e;
      mag = (total < 0) ? longint'(-total) : longint'(total);
      mag = mag >> 17;
      if (mag > 64'd32768) mag = 64'd32768;
      q = (total < 0) ? -longint'(mag) : longint'(mag);
      if (q > 32767) q = 32767;
      pid = int'(q);
      lw = drive_wheel(base_spd - pid);
      rw = drive_wheel(base_spd + pid);
      r.left_duty = lw.duty;
      r.left_reverse = lw.reverse;
      r.right_duty = rw.duty;
      r.right_reverse = rw.reverse;
      r.error_half = e[7:0];
      r.pid_output = pid[15:0];
      return r;
    endfunction

    function void note_scan(in_t it);
      pending_steer.push_back(steer_step(it));
    endfunction

    function void match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_steer(out_t got);
      out_t want;
      if (pending_steer.size() == 0) begin
        $error("result item arrived with no expected item pending");
        mismatches++;
        return;
      end
      want = pending_steer.pop_front();
      match_field("left_duty", want.left_duty, got.left_duty);
      match_field("left_reverse", want.left_reverse, got.left_reverse);
      match_field("right_duty", want.right_duty, got.right_duty);
      match_field("right_reverse", want.right_reverse, got.right_reverse);
      match_field("error_half", want.error_half, got.error_half);
      match_field("pid_output", want.pid_output, got.pid_output);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgDatW-1:0] cfg_data_i  = '0;

  steer_checker sb;
  int unsigned  idle_pct = 27;
  bit           hold_request = 1'b0;
  int unsigned  stuck_cycles = 0;

  line_follower_pid_steering_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_scan(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_steer(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
      @(negedge clk_i);
    end
  end

  task automatic send_item(input in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_steer.size() != 0) @(negedge clk_i);
    repeat (SettleTicks) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] vals [8]);
    reg_idx_e r;
    r = r.first();
    do begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_data_i <= vals[r];
      sb.set_reg(r, vals[r]);
      @(negedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] run_bits(int unsigned len, int unsigned lo);
    return 16'(((32'd1 << len) - 32'd1) << lo);
  endfunction

  function automatic in_t random_scan();
    in_t         it;
    int unsigned roll, len;
    roll = $urandom_range(0, 99);
    it.opcode = OP_SAMPLE;
    if (roll < 8) begin
      it.sensor_bits = $urandom_range(0, 1) ? 16'h8000 : 16'h0001;
    end else if (roll < 68) begin
      len = $urandom_range(2, 5);
      it.sensor_bits = run_bits(len, $urandom_range(0, 16 - len));
    end else if (roll < 82) begin
      it.sensor_bits = '0;
    end else if (roll < 89) begin
      it.sensor_bits = 16'($urandom);
    end else if (roll < 92) begin
      it.sensor_bits = run_bits(1, $urandom_range(1, 14));
    end else if (roll < 97) begin
      len = $urandom_range(6, 16);
      it.sensor_bits = run_bits(len, $urandom_range(0, 16 - len));
    end else begin
      it.opcode = OP_CLEAR;
      it.sensor_bits = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    in_t         directed [24];
    logic [31:0] regs_next [8];

    directed = '{
      '{OP_SAMPLE, 16'h0000}, '{OP_SAMPLE, 16'hFFFF}, '{OP_SAMPLE, 16'h0001},
      '{OP_SAMPLE, 16'h8000}, '{OP_SAMPLE, 16'h0003}, '{OP_SAMPLE, 16'h03C0},
      '{OP_SAMPLE, 16'h0180}, '{OP_SAMPLE, 16'h001F}, '{OP_SAMPLE, 16'h003F},
      '{OP_SAMPLE, 16'h0005}, '{OP_SAMPLE, 16'h0002}, '{OP_SAMPLE, 16'hC000},
      '{OP_SAMPLE, 16'h0000}, '{OP_SAMPLE, 16'h0000}, '{OP_SAMPLE, 16'h0003},
      '{OP_SAMPLE, 16'h0000}, '{OP_SAMPLE, 16'h0180}, '{OP_SAMPLE, 16'h0000},
      '{OP_SAMPLE, 16'h7C00}, '{OP_SAMPLE, 16'h0000}, '{OP_CLEAR,  16'hFFFF},
      '{OP_CLEAR,  16'h0000}, '{OP_SAMPLE, 16'hF800}, '{OP_SAMPLE, 16'h8000}
    };
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          4: begin
            regs_next[REG_PROP_GAIN]   = 32'hFFFF_FFFF;
            regs_next[REG_INTEG_GAIN]  = 32'hFFFF_FFFF;
            regs_next[REG_DERIV_GAIN]  = 32'hFFFF_FFFF;
            regs_next[REG_BASE_SPEED]  = 32'd32767;
            regs_next[REG_MAX_SPEED]   = 32'd32767;
            regs_next[REG_REV_OFFSET]  = 32'd32767;
            regs_next[REG_LOST_ERROR]  = 32'd63;
            regs_next[REG_LOST_ENABLE] = 32'd1;
          end
          5: begin
            foreach (regs_next[i]) regs_next[i] = '0;
          end
          6: begin
            foreach (regs_next[i]) regs_next[i] = $urandom;
          end
          8: begin
            regs_next[REG_PROP_GAIN]   = 32'd13107200;
            regs_next[REG_INTEG_GAIN]  = 32'd1114;
            regs_next[REG_DERIV_GAIN]  = 32'd36044800;
            regs_next[REG_BASE_SPEED]  = 32'd950;
            regs_next[REG_MAX_SPEED]   = 32'd1000;
            regs_next[REG_REV_OFFSET]  = 32'd400;
            regs_next[REG_LOST_ERROR]  = 32'd10;
            regs_next[REG_LOST_ENABLE] = 32'd0;
          end
          default: begin
            regs_next[REG_PROP_GAIN]   = $urandom_range(0, 32'h0200_0000);
            regs_next[REG_INTEG_GAIN]  = $urandom_range(0, 32'h0000_4000);
            regs_next[REG_DERIV_GAIN]  = $urandom_range(0, 32'h0400_0000);
            regs_next[REG_BASE_SPEED]  = $urandom_range(0, 1500);
            regs_next[REG_MAX_SPEED]   = $urandom_range(0, 1500);
            regs_next[REG_REV_OFFSET]  = $urandom_range(0, 800);
            regs_next[REG_LOST_ERROR]  = $urandom_range(0, 63);
            regs_next[REG_LOST_ENABLE] = (phase == 7) ? 32'd1 : $urandom_range(0, 1);
          end
        endcase
        program_regs(regs_next);
      end else begin
        foreach (directed[i]) send_item(directed[i]);
      end
      idle_pct = (phase == 2) ? 0 : 27;
      for (int n = 0; n < PhaseItems; n++) begin
        if ((phase == 1 || phase == 6) && n == 40) hold_request = 1'b1;
        send_item(random_scan());
      end
      in_valid_i <= 1'b0;
    end
    idle_pct = 27;
    drain();

    if (sb.mismatches == 0 && sb.pending_steer.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lfps_pkg.sv
hdl/lfps_decode.sv
hdl/lfps_wheel.sv
hdl/line_follower_pid_steering_top.sv
bench/line_follower_pid_steering_top_tb.sv
